// ===== rtl/core/noise_shake_slot_mixer_assert.svh =====
// assertion macros used by the shake slot mixer rtl
`ifndef NOISE_SHAKE_SLOT_MIXER_ASSERT_SVH
`define NOISE_SHAKE_SLOT_MIXER_ASSERT_SVH

// same-cycle implication, checked on the rising edge outside reset
`define NSSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on the rising edge outside reset
`define NSSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/nssm_pkg.sv =====
// ----------------------------------------------------------------------------
// nssm_pkg
// types, field codes and constants of the shake slot mixer
// ----------------------------------------------------------------------------
`default_nettype none

package nssm_pkg;

    // field widths
    localparam int TIME_W   = 24;
    localparam int SEED_W   = 32;
    localparam int AMP_W    = 16;
    localparam int AMPS_W   = 48;
    localparam int OUT_W    = 32;
    localparam int ACC_W    = 40;
    localparam int ENV_W    = 17;
    localparam int NOISE_W  = 25;
    localparam int SMTH_W   = 17;
    localparam int DIV_W    = 40;
    localparam int STREAMS  = 6;

    localparam int SLOTS_DEF = 16;

    localparam logic [TIME_W-1:0] TIME_MAX  = '1;
    localparam logic [ENV_W-1:0]  ENV_ONE   = 17'h10000;
    localparam logic [31:0]       HASH_MUL1 = 32'h7feb352d;
    localparam logic [31:0]       HASH_MUL2 = 32'h846ca68b;
    localparam logic [17:0]       SMOOTH_K  = 18'd196608;

    // seed offsets: position x,y,z then rotation x,y,z
    localparam logic [6:0] SEED_OFS [STREAMS] = '{7'd1, 7'd2, 7'd3, 7'd101, 7'd102, 7'd103};

    // item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // field selector codes
    localparam logic [3:0] FLD_ACTIVE    = 4'd0;
    localparam logic [3:0] FLD_SEED      = 4'd1;
    localparam logic [3:0] FLD_ELAPSED   = 4'd2;
    localparam logic [3:0] FLD_DURATION  = 4'd3;
    localparam logic [3:0] FLD_BLEND_IN  = 4'd4;
    localparam logic [3:0] FLD_BLEND_OUT = 4'd5;
    localparam logic [3:0] FLD_FREQUENCY = 4'd6;
    localparam logic [3:0] FLD_POS_X     = 4'd7;
    localparam logic [3:0] FLD_POS_Y     = 4'd8;
    localparam logic [3:0] FLD_POS_Z     = 4'd9;
    localparam logic [3:0] FLD_ROT_X     = 4'd10;
    localparam logic [3:0] FLD_ROT_Y     = 4'd11;
    localparam logic [3:0] FLD_ROT_Z     = 4'd12;

    typedef struct packed {
        logic                      action;
        logic [3:0]                slot;
        logic [3:0]                field_sel;
        logic [31:0]               write_value;
        logic signed [TIME_W-1:0]  time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] pos_x;
        logic signed [OUT_W-1:0] pos_y;
        logic signed [OUT_W-1:0] pos_z;
        logic signed [OUT_W-1:0] rot_x;
        logic signed [OUT_W-1:0] rot_y;
        logic signed [OUT_W-1:0] rot_z;
    } t_out_item;

    // one slot record as held in the slot memory
    typedef struct packed {
        logic               active;
        logic [SEED_W-1:0]  seed;
        logic [TIME_W-1:0]  elapsed;
        logic [TIME_W-1:0]  duration;
        logic [TIME_W-1:0]  blend_in;
        logic [TIME_W-1:0]  blend_out;
        logic [TIME_W-1:0]  frequency;
        logic [AMPS_W-1:0]  pos_amp;
        logic [AMPS_W-1:0]  rot_amp;
    } t_slot;

endpackage

`default_nettype wire

// ===== rtl/core/nssm_ram.sv =====
// ----------------------------------------------------------------------------
// nssm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module nssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/nssm_div.sv =====
// ----------------------------------------------------------------------------
// nssm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module nssm_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [nssm_pkg::DIV_W-1:0]       i_num,
    input  wire logic [nssm_pkg::TIME_W-1:0]      i_den,
    output logic                                  o_done,
    output logic      [nssm_pkg::DIV_W-1:0]       o_quot
);

    localparam int NW = nssm_pkg::DIV_W;
    localparam int DW = nssm_pkg::TIME_W;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   trial;
    logic          ge;

    // trial subtraction of the shifted remainder
    assign trial = {r_rem, r_quo[NW-1]};
    assign ge    = (trial >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// ===== rtl/core/nssm_hash.sv =====
// ----------------------------------------------------------------------------
// nssm_hash
// three stage lowbias32 integer hash
// ----------------------------------------------------------------------------
`default_nettype none

module nssm_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_x,
    output logic             o_done,
    output logic      [31:0] o_hash
);

    logic [2:0]  r_vld;
    logic [31:0] r_x1;
    logic [31:0] r_y;
    logic [31:0] r_z;
    logic [31:0] y_mix;

    assign y_mix = r_y ^ (r_y >> 15);

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    // xor-shift, multiply, xor-shift and multiply
    always_ff @(posedge i_clk) begin
        r_x1 <= i_x ^ (i_x >> 16);
        r_y  <= 32'(r_x1 * nssm_pkg::HASH_MUL1);
        r_z  <= 32'(y_mix * nssm_pkg::HASH_MUL2);
    end

    assign o_done = r_vld[2];
    assign o_hash = r_z ^ (r_z >> 16);

endmodule

`default_nettype wire

// ===== rtl/core/noise_shake_slot_mixer.sv =====
// ----------------------------------------------------------------------------
// noise_shake_slot_mixer
// shake slot table with per-tick smoothstep value noise mixing
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_item (nssm_pkg::t_in_item)
//   output   out        o_valid / i_ready    o_item (nssm_pkg::t_out_item)
//
// a field write reads, modifies and writes back one slot record
// a tick walks every slot: an inactive slot is only read, an expiring one is read
// and cleared, and a live slot is bound by the shared serial divider (once per
// envelope ramp that divides) and the shared hash unit (twelve hashes)
// after reset a clearing pass writes every slot with o_ready low
// a finished tick waits in place while the output register is still held
// ----------------------------------------------------------------------------
`default_nettype none

`include "noise_shake_slot_mixer_assert.svh"

module noise_shake_slot_mixer #(
    parameter int SLOTS = nssm_pkg::SLOTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire nssm_pkg::t_in_item   i_item,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output nssm_pkg::t_out_item       o_item
);

    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int REC_W = $bits(nssm_pkg::t_slot);
    localparam int TW    = nssm_pkg::TIME_W;
    localparam int AC    = nssm_pkg::ACC_W;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef enum logic [22:0] {
        S_CLR    = 23'b1 << 0,
        S_IDLE   = 23'b1 << 1,
        S_WR_RD  = 23'b1 << 2,
        S_WR_WB  = 23'b1 << 3,
        S_TK_RD  = 23'b1 << 4,
        S_TK_LD  = 23'b1 << 5,
        S_TK_PH  = 23'b1 << 6,
        S_TK_SM1 = 23'b1 << 7,
        S_TK_SM2 = 23'b1 << 8,
        S_TK_DV1 = 23'b1 << 9,
        S_TK_DW1 = 23'b1 << 10,
        S_TK_DV2 = 23'b1 << 11,
        S_TK_DW2 = 23'b1 << 12,
        S_TK_HA  = 23'b1 << 13,
        S_TK_HAW = 23'b1 << 14,
        S_TK_HB  = 23'b1 << 15,
        S_TK_HBW = 23'b1 << 16,
        S_TK_M1  = 23'b1 << 17,
        S_TK_M2  = 23'b1 << 18,
        S_TK_M3  = 23'b1 << 19,
        S_TK_ACC = 23'b1 << 20,
        S_TK_NXT = 23'b1 << 21,
        S_TK_OUT = 23'b1 << 22
    } t_state;

    t_state                       r_state, n_state;
    logic [AW-1:0]                r_addr;
    nssm_pkg::t_in_item           r_item;
    logic [TW-1:0]                r_step;
    nssm_pkg::t_slot              r_rec;
    logic [47:0]                  r_phase;
    logic [15:0]                  r_f2;
    logic [nssm_pkg::SMTH_W-1:0]  r_s;
    logic [nssm_pkg::ENV_W-1:0]   r_env;
    logic [2:0]                   r_j;
    logic signed [23:0]           r_a;
    logic signed [23:0]           r_b;
    logic signed [42:0]           r_d;
    logic signed [nssm_pkg::NOISE_W-1:0] r_n;
    logic signed [33:0]           r_p;
    logic signed [58:0]           r_c;
    logic signed [AC-1:0]         r_acc [nssm_pkg::STREAMS];
    nssm_pkg::t_out_item          r_out;
    logic                         r_out_valid;

    logic                         accept;
    logic [8:0]                   slot_ext;
    logic                         mem_we;
    logic [REC_W-1:0]             mem_wdata;
    logic [REC_W-1:0]             mem_rdata;
    nssm_pkg::t_slot              rd_rec;
    logic [TW:0]                  e_sum;
    logic [TW-1:0]                e_new;
    logic                         expired;
    nssm_pkg::t_slot              live_rec;
    logic [TW-1:0]                rem_time;
    logic                         div_start;
    logic [nssm_pkg::DIV_W-1:0]   div_num;
    logic [TW-1:0]                div_den;
    logic                         div_done;
    logic [nssm_pkg::DIV_W-1:0]   div_quot;
    logic                         hash_start;
    logic [31:0]                  hash_x;
    logic [31:0]                  seed_k;
    logic [31:0]                  lat_cell;
    logic                         hash_done;
    logic [31:0]                  hash_val;
    logic signed [23:0]           hash_s;
    logic [15:0]                  frac;
    logic [17:0]                  smooth_k;
    logic [33:0]                  smooth_p;
    logic signed [24:0]           ba_diff;
    logic signed [15:0]           amp;

    // one field of a slot record replaced by a write item
    function automatic nssm_pkg::t_slot apply_field(nssm_pkg::t_slot rec,
                                                    logic [3:0] sel, logic [31:0] v);
        nssm_pkg::t_slot r;
        r = rec;
        unique case (sel)
            nssm_pkg::FLD_ACTIVE:    r.active          = v[0];
            nssm_pkg::FLD_SEED:      r.seed            = v;
            nssm_pkg::FLD_ELAPSED:   r.elapsed         = v[TW-1:0];
            nssm_pkg::FLD_DURATION:  r.duration        = v[TW-1:0];
            nssm_pkg::FLD_BLEND_IN:  r.blend_in        = v[TW-1:0];
            nssm_pkg::FLD_BLEND_OUT: r.blend_out       = v[TW-1:0];
            nssm_pkg::FLD_FREQUENCY: r.frequency       = v[TW-1:0];
            nssm_pkg::FLD_POS_X:     r.pos_amp[15:0]   = v[15:0];
            nssm_pkg::FLD_POS_Y:     r.pos_amp[31:16]  = v[15:0];
            nssm_pkg::FLD_POS_Z:     r.pos_amp[47:32]  = v[15:0];
            nssm_pkg::FLD_ROT_X:     r.rot_amp[15:0]   = v[15:0];
            nssm_pkg::FLD_ROT_Y:     r.rot_amp[31:16]  = v[15:0];
            nssm_pkg::FLD_ROT_Z:     r.rot_amp[47:32]  = v[15:0];
            default: ;
        endcase
        return r;
    endfunction

    // amplitude lane of one stream
    function automatic logic signed [15:0] amp_lane(nssm_pkg::t_slot rec, logic [2:0] j);
        logic signed [15:0] a;
        case (j)
            3'd0:    a = rec.pos_amp[15:0];
            3'd1:    a = rec.pos_amp[31:16];
            3'd2:    a = rec.pos_amp[47:32];
            3'd3:    a = rec.rot_amp[15:0];
            3'd4:    a = rec.rot_amp[31:16];
            3'd5:    a = rec.rot_amp[47:32];
            default: a = '0;
        endcase
        return a;
    endfunction

    // saturate an accumulator to the output range
    function automatic logic signed [31:0] sat32(logic signed [AC-1:0] v);
        logic signed [31:0] r;
        if (v > AC'(signed'(32'sh7fffffff))) begin
            r = 32'sh7fffffff;
        end else if (v < AC'(signed'(32'sh80000000))) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign slot_ext = 9'(i_item.slot);

    // slot memory
    nssm_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    // elapsed update and expiry of the slot just read
    assign rd_rec   = nssm_pkg::t_slot'(mem_rdata);
    assign e_sum    = {1'b0, rd_rec.elapsed} + {1'b0, r_step};
    assign e_new    = e_sum[TW] ? nssm_pkg::TIME_MAX : e_sum[TW-1:0];
    assign expired  = (rd_rec.duration != '0) && (e_new >= rd_rec.duration);
    always_comb begin
        live_rec         = rd_rec;
        live_rec.elapsed = e_new;
    end

    // memory write selection
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_WR_WB: begin
                mem_we    = 1'b1;
                mem_wdata = apply_field(rd_rec, r_item.field_sel, r_item.write_value);
            end
            S_TK_LD: begin
                mem_we    = rd_rec.active;
                mem_wdata = expired ? '0 : live_rec;
            end
            default: ;
        endcase
    end

    // envelope ramp divisions
    assign rem_time = (r_rec.duration > r_rec.elapsed) ?
                      (r_rec.duration - r_rec.elapsed) : '0;
    always_comb begin
        div_start = 1'b0;
        div_num   = {r_rec.elapsed, 16'h0000};
        div_den   = r_rec.blend_in;
        if (r_state == S_TK_DV1) begin
            div_start = (r_rec.blend_in != '0);
        end else if (r_state == S_TK_DV2) begin
            div_start = (r_rec.duration != '0) && (r_rec.blend_out != '0);
            div_num   = {rem_time, 16'h0000};
            div_den   = r_rec.blend_out;
        end
    end

    nssm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // hash input: lattice cell or its neighbour, xored with the stream seed
    assign lat_cell   = {16'h0000, r_phase[47:32]};
    assign seed_k     = r_rec.seed + 32'(nssm_pkg::SEED_OFS[r_j]);
    assign hash_start = (r_state == S_TK_HA) || (r_state == S_TK_HB);
    assign hash_x     = ((r_state == S_TK_HB) ? (lat_cell + 32'd1) : lat_cell) ^ seed_k;

    nssm_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_x     (hash_x),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    // top 24 hash bits less 2^23 is the top bit flipped
    assign hash_s   = {~hash_val[31], hash_val[30:8]};
    assign frac     = r_phase[31:16];
    assign smooth_k = nssm_pkg::SMOOTH_K - {1'b0, frac, 1'b0};
    assign smooth_p = 34'(r_f2) * 34'(smooth_k);
    assign ba_diff  = 25'(r_b) - 25'(r_a);
    assign amp      = amp_lane(r_rec, r_j);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:    if (r_addr == LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (i_item.action == nssm_pkg::ACT_TICK) begin
                        n_state = S_TK_RD;
                    end else if (slot_ext < 9'(SLOTS)) begin
                        n_state = S_WR_RD;
                    end
                end
            end
            S_WR_RD:  n_state = S_WR_WB;
            S_WR_WB:  n_state = S_IDLE;
            S_TK_RD:  n_state = S_TK_LD;
            S_TK_LD:  n_state = (rd_rec.active && !expired) ? S_TK_PH : S_TK_NXT;
            S_TK_PH:  n_state = S_TK_SM1;
            S_TK_SM1: n_state = S_TK_SM2;
            S_TK_SM2: n_state = S_TK_DV1;
            S_TK_DV1: n_state = div_start ? S_TK_DW1 : S_TK_DV2;
            S_TK_DW1: if (div_done) n_state = S_TK_DV2;
            S_TK_DV2: n_state = div_start ? S_TK_DW2 : S_TK_HA;
            S_TK_DW2: if (div_done) n_state = S_TK_HA;
            S_TK_HA:  n_state = S_TK_HAW;
            S_TK_HAW: if (hash_done) n_state = S_TK_HB;
            S_TK_HB:  n_state = S_TK_HBW;
            S_TK_HBW: if (hash_done) n_state = S_TK_M1;
            S_TK_M1:  n_state = S_TK_M2;
            S_TK_M2:  n_state = S_TK_M3;
            S_TK_M3:  n_state = S_TK_ACC;
            S_TK_ACC: n_state = (r_j == 3'(nssm_pkg::STREAMS - 1)) ? S_TK_NXT : S_TK_HA;
            S_TK_NXT: n_state = (r_addr == LAST) ? S_TK_OUT : S_TK_RD;
            S_TK_OUT: if (!r_out_valid) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    if (r_addr != LAST) r_addr <= r_addr + AW'(1);
                    else                r_addr <= '0;
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_item.action == nssm_pkg::ACT_TICK) r_addr <= '0;
                        else                                     r_addr <= slot_ext[AW-1:0];
                    end
                end
                S_TK_NXT: begin
                    if (r_addr != LAST) r_addr <= r_addr + AW'(1);
                end
                S_TK_OUT: begin
                    if (!r_out_valid) r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_item <= i_item;
                    r_step <= i_item.time_step[TW-1] ? '0 : i_item.time_step;
                    for (int k = 0; k < nssm_pkg::STREAMS; k++) begin
                        r_acc[k] <= '0;
                    end
                end
            end
            S_TK_LD:  r_rec   <= live_rec;
            S_TK_PH: begin
                r_phase <= 48'(r_rec.elapsed) * 48'(r_rec.frequency);
                r_j     <= '0;
            end
            S_TK_SM1: r_f2 <= 16'((32'(frac) * 32'(frac)) >> 16);
            S_TK_SM2: begin
                r_s   <= smooth_p[32:16];
                r_env <= nssm_pkg::ENV_ONE;
            end
            S_TK_DW1, S_TK_DW2: begin
                if (div_done && (div_quot < nssm_pkg::DIV_W'(r_env))) begin
                    r_env <= div_quot[nssm_pkg::ENV_W-1:0];
                end
            end
            S_TK_HAW: if (hash_done) r_a <= hash_s;
            S_TK_HBW: if (hash_done) r_b <= hash_s;
            S_TK_M1:  r_d <= 43'(ba_diff) * 43'($signed({1'b0, r_s}));
            S_TK_M2: begin
                r_n <= 25'(43'(r_a) + (r_d >>> 16));
                r_p <= 34'(amp) * 34'($signed({1'b0, r_env}));
            end
            S_TK_M3:  r_c <= 59'(r_p) * 59'(r_n);
            S_TK_ACC: begin
                r_acc[r_j] <= r_acc[r_j] + AC'(r_c >>> 31);
                r_j        <= r_j + 3'd1;
            end
            S_TK_OUT: begin
                if (!r_out_valid) begin
                    r_out.pos_x <= sat32(r_acc[0]);
                    r_out.pos_y <= sat32(r_acc[1]);
                    r_out.pos_z <= sat32(r_acc[2]);
                    r_out.rot_x <= sat32(r_acc[3]);
                    r_out.rot_y <= sat32(r_acc[4]);
                    r_out.rot_z <= sat32(r_acc[5]);
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // checks on the sequencer
    `NSSM_ASSERT_IMPL(a_mem_we_state, i_clk, i_rst_n, mem_we, (r_state == S_CLR || r_state == S_WR_WB || r_state == S_TK_LD), "slot memory written outside a write state")
    `NSSM_ASSERT_NEXT(a_tick_starts, i_clk, i_rst_n, (accept && i_item.action == nssm_pkg::ACT_TICK), (r_state == S_TK_RD), "tick item did not start a slot walk")
    `NSSM_ASSERT_IMPL(a_hash_wait, i_clk, i_rst_n, hash_done, (r_state == S_TK_HAW || r_state == S_TK_HBW), "hash result arrived while not waiting")
    `NSSM_ASSERT_IMPL(a_div_wait, i_clk, i_rst_n, div_done, (r_state == S_TK_DW1 || r_state == S_TK_DW2), "quotient arrived while not waiting")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the shake slot mixer against a built-in model of the slot table: slots
// are filled by field writes and mixed by ticks, and each tick's six outputs
// are compared with the predicted sums, under several idling phases
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS   = 16;
    localparam int IDLE_LIMIT = 200000;

    // shake table model with a queue of expected tick sums
    class shake_scoreboard;
        bit        active   [N_SLOTS];
        bit [31:0] seed     [N_SLOTS];
        bit [23:0] elapsed  [N_SLOTS];
        bit [23:0] duration [N_SLOTS];
        bit [23:0] blend_in [N_SLOTS];
        bit [23:0] blend_out[N_SLOTS];
        bit [23:0] freq     [N_SLOTS];
        bit [47:0] pos_amp  [N_SLOTS];
        bit [47:0] rot_amp  [N_SLOTS];
        nssm_pkg::t_out_item pending_sums[$];
        int        mismatches;

        function void clear_slot(int i);
            active[i] = 0; seed[i] = 0; elapsed[i] = 0; duration[i] = 0;
            blend_in[i] = 0; blend_out[i] = 0; freq[i] = 0;
            pos_amp[i] = 0; rot_amp[i] = 0;
        endfunction

        function void wipe();
            for (int i = 0; i < N_SLOTS; i++) clear_slot(i);
        endfunction

        function bit [31:0] lowbias(bit [31:0] x);
            x ^= x >> 16;
            x = x * nssm_pkg::HASH_MUL1;
            x ^= x >> 15;
            x = x * nssm_pkg::HASH_MUL2;
            x ^= x >> 16;
            return x;
        endfunction

        function longint hash_q23(bit [31:0] x);
            bit [31:0] h;
            h = lowbias(x);
            return longint'(h >> 8) - 64'sd8388608;
        endfunction

        // floor division by 2^n
        function longint floor_sh(longint v, int n);
            return v >>> n;
        endfunction

        function longint envelope(int i);
            longint env, r, rem;
            env = 65536;
            if (blend_in[i] != 0) begin
                r = (longint'(elapsed[i]) << 16) / longint'(blend_in[i]);
                if (r < env) env = r;
            end
            if (duration[i] != 0 && blend_out[i] != 0) begin
                rem = (duration[i] > elapsed[i]) ? longint'(duration[i] - elapsed[i]) : 0;
                r = (rem << 16) / longint'(blend_out[i]);
                if (r < env) env = r;
            end
            return env;
        endfunction

        function void note_item(nssm_pkg::t_in_item it);
            longint sums[6];
            bit [31:0] ofs[6] = '{1, 2, 3, 101, 102, 103};
            bit [23:0] stp;
            bit [24:0] e;
            bit [63:0] phase;
            bit [31:0] lat_cell, sd;
            longint frac, f2, s, a, b, n, amp, env;
            bit [47:0] amps;
            bit [15:0] lane;
            nssm_pkg::t_out_item r;
            int i, j;
            if (it.action == nssm_pkg::ACT_WRITE) begin
                i = it.slot;
                case (it.field_sel)
                    nssm_pkg::FLD_ACTIVE:    active[i] = it.write_value[0];
                    nssm_pkg::FLD_SEED:      seed[i] = it.write_value;
                    nssm_pkg::FLD_ELAPSED:   elapsed[i] = it.write_value[23:0];
                    nssm_pkg::FLD_DURATION:  duration[i] = it.write_value[23:0];
                    nssm_pkg::FLD_BLEND_IN:  blend_in[i] = it.write_value[23:0];
                    nssm_pkg::FLD_BLEND_OUT: blend_out[i] = it.write_value[23:0];
                    nssm_pkg::FLD_FREQUENCY: freq[i] = it.write_value[23:0];
                    nssm_pkg::FLD_POS_X:     pos_amp[i][15:0]  = it.write_value[15:0];
                    nssm_pkg::FLD_POS_Y:     pos_amp[i][31:16] = it.write_value[15:0];
                    nssm_pkg::FLD_POS_Z:     pos_amp[i][47:32] = it.write_value[15:0];
                    nssm_pkg::FLD_ROT_X:     rot_amp[i][15:0]  = it.write_value[15:0];
                    nssm_pkg::FLD_ROT_Y:     rot_amp[i][31:16] = it.write_value[15:0];
                    nssm_pkg::FLD_ROT_Z:     rot_amp[i][47:32] = it.write_value[15:0];
                    default: ;
                endcase
                return;
            end
            foreach (sums[k]) sums[k] = 0;
            stp = it.time_step[23] ? 24'd0 : it.time_step;
            for (i = 0; i < N_SLOTS; i++) begin
                if (!active[i]) continue;
                e = elapsed[i] + stp;
                elapsed[i] = e[24] ? nssm_pkg::TIME_MAX : e[23:0];
                if (duration[i] != 0 && elapsed[i] >= duration[i]) begin
                    clear_slot(i);
                    continue;
                end
                env = envelope(i);
                phase = 64'(elapsed[i]) * 64'(freq[i]);
                lat_cell = phase[63:32];
                frac = longint'(phase[31:16]);
                f2 = (frac * frac) >> 16;
                s = (f2 * (196608 - 2 * frac)) >> 16;
                for (j = 0; j < 6; j++) begin
                    amps = (j < 3) ? pos_amp[i] : rot_amp[i];
                    lane = amps[16*(j%3) +: 16];
                    amp = longint'($signed(lane));
                    sd = seed[i] + ofs[j];
                    a = hash_q23(lat_cell ^ sd);
                    b = hash_q23((lat_cell + 32'd1) ^ sd);
                    n = a + floor_sh((b - a) * s, 16);
                    sums[j] += floor_sh(amp * env * n, 31);
                end
            end
            foreach (sums[k]) begin
                if (sums[k] > 64'sd2147483647) sums[k] = 64'sd2147483647;
                if (sums[k] < -64'sd2147483648) sums[k] = -64'sd2147483648;
            end
            r.pos_x = sums[0][31:0]; r.pos_y = sums[1][31:0]; r.pos_z = sums[2][31:0];
            r.rot_x = sums[3][31:0]; r.rot_y = sums[4][31:0]; r.rot_z = sums[5][31:0];
            pending_sums.push_back(r);
        endfunction

        function void check_sums(nssm_pkg::t_out_item got);
            nssm_pkg::t_out_item want;
            if (pending_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_sums.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                        want.pos_x, want.pos_y, want.pos_z, want.rot_x, want.rot_y,
                        want.rot_z, got.pos_x, got.pos_y, got.pos_z, got.rot_x,
                        got.rot_y, got.rot_z);
            end
        endfunction
    endclass

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                i_valid = 0;
    logic                o_ready;
    nssm_pkg::t_in_item  i_item = '0;
    logic                o_valid;
    logic                i_ready = 0;
    nssm_pkg::t_out_item o_item;

    shake_scoreboard board;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    bit stim_done = 0;

    noise_shake_slot_mixer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // result side: sample at the rising edge, stall at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) board.check_sums(o_item);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // valid stays high into the next item when there is no idle gap
    task automatic send_item(nssm_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_item  <= it;
        i_valid <= 1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic write_field(int slot, logic [3:0] sel, logic [31:0] v);
        nssm_pkg::t_in_item it;
        it = '0;
        it.action = nssm_pkg::ACT_WRITE;
        it.slot = 4'(slot);
        it.field_sel = sel;
        it.write_value = v;
        it.time_step = 24'($urandom);
        send_item(it);
    endtask

    task automatic tick(logic [23:0] stp);
        nssm_pkg::t_in_item it;
        it = '0;
        it.action = nssm_pkg::ACT_TICK;
        it.slot = 4'($urandom);
        it.field_sel = 4'($urandom);
        it.write_value = $urandom;
        it.time_step = stp;
        send_item(it);
    endtask

    // small random step, occasionally anything or a negative one
    function automatic logic [23:0] pick_step();
        case ($urandom_range(9))
            0: return 24'($urandom);
            1: return 24'h800000 | 24'($urandom_range(255));
            default: return 24'($urandom_range(8000));
        endcase
    endfunction

    // fill one slot with random but sensible values
    task automatic fill_slot(int s);
        write_field(s, nssm_pkg::FLD_SEED, $urandom);
        write_field(s, nssm_pkg::FLD_ELAPSED,
                    $urandom_range(3) == 0 ? $urandom : $urandom_range(20000));
        write_field(s, nssm_pkg::FLD_DURATION,
                    $urandom_range(2) == 0 ? 0 : $urandom_range(200000));
        write_field(s, nssm_pkg::FLD_BLEND_IN,
                    $urandom_range(1) ? 0 : $urandom_range(40000));
        write_field(s, nssm_pkg::FLD_BLEND_OUT,
                    $urandom_range(1) ? 0 : $urandom_range(40000));
        write_field(s, nssm_pkg::FLD_FREQUENCY,
                    $urandom_range(3) == 0 ? $urandom : $urandom_range(1000000));
        for (int k = 0; k < 6; k++) write_field(s, 4'(nssm_pkg::FLD_POS_X + k), $urandom);
        write_field(s, nssm_pkg::FLD_ACTIVE, 32'({$urandom_range(31), 1'b1}));
    endtask

    initial begin
        int phase_pct[4][2] = '{'{0, 0}, '{56, 0}, '{0, 56}, '{37, 37}};
        int r;
        board = new();
        board.wipe();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: empty tick, extremes, ignored selectors, expiry, overflow
        tick(24'h000100);
        write_field(0, nssm_pkg::FLD_SEED, 32'hFFFFFFFF);
        write_field(0, nssm_pkg::FLD_FREQUENCY, 32'hFFFFFFFF);
        write_field(0, nssm_pkg::FLD_POS_X, 32'h00007FFF);
        write_field(0, nssm_pkg::FLD_POS_Y, 32'h00008000);
        write_field(0, nssm_pkg::FLD_POS_Z, 32'hFFFFFFFF);
        write_field(0, nssm_pkg::FLD_ROT_X, 32'h7FFF);
        write_field(0, nssm_pkg::FLD_ROT_Y, 32'h8000);
        write_field(0, nssm_pkg::FLD_ROT_Z, 32'h1234);
        write_field(0, nssm_pkg::FLD_ELAPSED, 32'hFFFFFF00);
        write_field(0, nssm_pkg::FLD_ACTIVE, 32'hFFFFFFFF);
        write_field(15, 4'd13, 32'hFFFFFFFF);
        write_field(15, 4'd15, 32'hFFFFFFFF);
        tick(24'h7FFFFF);
        tick(24'h800000);
        write_field(15, nssm_pkg::FLD_DURATION, 32'h000100);
        write_field(15, nssm_pkg::FLD_BLEND_IN, 32'h80);
        write_field(15, nssm_pkg::FLD_BLEND_OUT, 32'hFFFFFF);
        write_field(15, nssm_pkg::FLD_POS_X, 32'h4000);
        write_field(15, nssm_pkg::FLD_FREQUENCY, 32'h010000);
        write_field(15, nssm_pkg::FLD_ACTIVE, 1);
        tick(24'h000080);
        tick(24'h000080);
        tick(24'hFFFFFF);

        // random phases: mostly slot fills and ticks with some noise writes
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_pct[p][0];
            recv_stall_pct = phase_pct[p][1];
            for (int n = 0; n < 250; n++) begin
                r = $urandom_range(99);
                if (r < 6) begin
                    fill_slot($urandom_range(N_SLOTS - 1));
                    n += 12;
                end else if (r < 55) tick(pick_step());
                else if (r < 65) write_field($urandom_range(N_SLOTS - 1),
                                             nssm_pkg::FLD_ACTIVE, $urandom);
                else write_field($urandom, 4'($urandom), $urandom);
            end
            // a stretch with no idling
            send_idle_pct = 0;
            recv_stall_pct = 0;
            repeat (20) tick(pick_step());
        end
        i_valid <= 0;

        @(negedge i_clk);
        while (board.pending_sums.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (board.mismatches == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/nssm_pkg.sv
rtl/core/nssm_ram.sv
rtl/core/nssm_div.sv
rtl/core/nssm_hash.sv
rtl/core/noise_shake_slot_mixer.sv
bench/tb.sv
